@@ design/sptex_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sprite texture sampler package
// Shared constants, codes, the side-band beat type and a small helper function.
// ----------------------------------------------------------------------------
package sptex_pkg;

  localparam int unsigned SCREEN_WIDTH_DEF     = 640;
  localparam int unsigned SCREEN_HEIGHT_DEF    = 480;
  localparam int unsigned TEXTURE_SIDE_MAX_DEF = 64;
  localparam int unsigned FRAMES_MAX_DEF       = 8;

  localparam logic [31:0] OPAQUE_MASK = 32'h00FF_FFFF;

  typedef enum logic [1:0] {
    OP_LOAD_DEPTH = 2'd0,
    OP_LOAD_TEXEL = 2'd1,
    OP_SHADE      = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CFG_TEXTURE_WIDTH   = 2'd0,
    CFG_TEXTURE_HEIGHT  = 2'd1,
    CFG_FRAME_COUNT     = 2'd2,
    CFG_ANIMATION_FRAME = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic        shade;
    logic        twr;
    logic [9:0]  px;
    logic [8:0]  py;
    logic [14:0] tidx;
    logic [31:0] tval;
  } side_t;

  function automatic logic [3:0] frame_wrap(input logic [2:0] f, input int unsigned fmax);
    logic [4:0] v;
    v = {2'b00, f};
    for (int i = 0; i < 8; i++) begin
      if (v >= fmax) begin
        v = v - 5'(fmax);
      end
    end
    return v[3:0];
  endfunction

endpackage
`default_nettype wire

@@ design/sptex_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sprite texture sampler front end
// Takes beats, keeps the column depth store, runs the depth test and forms
// the dividends of both texture coordinates.
// ----------------------------------------------------------------------------
module sptex_front #(
  parameter int unsigned SCREEN_WIDTH     = sptex_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT    = sptex_pkg::SCREEN_HEIGHT_DEF,
  parameter int unsigned TEXTURE_SIDE_MAX = sptex_pkg::TEXTURE_SIDE_MAX_DEF,
  parameter int unsigned FRAMES_MAX       = sptex_pkg::FRAMES_MAX_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  wire logic                       in_valid_i,
  input  wire logic [1:0]                 operation_i,
  input  wire logic signed [15:0]         column_i,
  input  wire logic signed [15:0]         row_i,
  input  wire logic signed [15:0]         sprite_center_x_i,
  input  wire logic [15:0]                sprite_width_i,
  input  wire logic [15:0]                sprite_height_i,
  input  wire logic [31:0]                sprite_depth_i,
  input  wire logic [31:0]                depth_value_i,
  input  wire logic [14:0]                texel_index_i,
  input  wire logic [31:0]                texel_value_i,
  input  wire logic [$clog2(TEXTURE_SIDE_MAX+1)-1:0] tex_w_i,
  input  wire logic [$clog2(TEXTURE_SIDE_MAX+1)-1:0] tex_h_i,
  output sptex_pkg::side_t                side_o,
  output logic [15+$clog2(TEXTURE_SIDE_MAX+1):0] num_x_o,
  output logic [15:0]                     den_x_o,
  output logic                            neg_x_o,
  output logic                            big_x_o,
  output logic [15+$clog2(TEXTURE_SIDE_MAX+1):0] num_y_o,
  output logic [15:0]                     den_y_o,
  output logic                            neg_y_o,
  output logic                            big_y_o
);

  localparam int unsigned DW     = $clog2(SCREEN_WIDTH);
  localparam int unsigned SW_W   = $clog2(TEXTURE_SIDE_MAX + 1);
  localparam int unsigned NW     = 16 + SW_W;
  localparam int unsigned TEXELS = FRAMES_MAX * TEXTURE_SIDE_MAX * TEXTURE_SIDE_MAX;

  logic [31:0] dmem [SCREEN_WIDTH];
  logic        accept;
  logic        col_ok;
  logic        row_ok;
  logic [DW-1:0] didx;
  logic [15:0] sw1;
  logic [15:0] sh1;
  logic [17:0] dx_d;
  logic [17:0] dy_d;

  logic        s1_shade_q;
  logic        s1_twr_q;
  logic [9:0]  s1_px_q;
  logic [8:0]  s1_py_q;
  logic [14:0] s1_tidx_q;
  logic [31:0] s1_tval_q;
  logic [31:0] s1_sdepth_q;
  logic [31:0] s1_dq_q;
  logic [17:0] s1_dx_q;
  logic [17:0] s1_dy_q;
  logic [15:0] s1_sw_q;
  logic [15:0] s1_sh_q;

  sptex_pkg::side_t s2_side_q;
  logic [NW-1:0]    s2_nx_q;
  logic [NW-1:0]    s2_ny_q;
  logic [15:0]      s2_sw_q;
  logic [15:0]      s2_sh_q;
  logic             s2_negx_q;
  logic             s2_bigx_q;
  logic             s2_negy_q;
  logic             s2_bigy_q;

  assign accept = in_valid_i & en_i;
  assign col_ok = (column_i >= 0) && (column_i < $signed(SCREEN_WIDTH));
  assign row_ok = (row_i >= 0) && (row_i < $signed(SCREEN_HEIGHT));
  assign didx   = column_i[DW-1:0];
  assign sw1    = (sprite_width_i == 16'd0) ? 16'd1 : sprite_width_i;
  assign sh1    = (sprite_height_i == 16'd0) ? 16'd1 : sprite_height_i;
  assign dx_d   = 18'(column_i) - 18'(sprite_center_x_i) + 18'(sw1[15:1]);
  assign dy_d   = 18'(row_i) - 18'(SCREEN_HEIGHT / 2) + 18'(sh1[15:1]);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if ((operation_i == sptex_pkg::OP_LOAD_DEPTH) && col_ok) begin
        dmem[didx] <= depth_value_i;
      end
      s1_dq_q <= dmem[didx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_shade_q <= 1'b0;
      s1_twr_q   <= 1'b0;
      s2_side_q  <= '0;
    end else if (en_i) begin
      s1_shade_q <= accept && (operation_i == sptex_pkg::OP_SHADE) && col_ok && row_ok;
      s1_twr_q   <= accept && (operation_i == sptex_pkg::OP_LOAD_TEXEL) &&
                    (32'(texel_index_i) < TEXELS);
      s2_side_q.shade <= s1_shade_q && (s1_sdepth_q < s1_dq_q);
      s2_side_q.twr   <= s1_twr_q;
      s2_side_q.px    <= s1_px_q;
      s2_side_q.py    <= s1_py_q;
      s2_side_q.tidx  <= s1_tidx_q;
      s2_side_q.tval  <= s1_tval_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_px_q     <= column_i[9:0];
      s1_py_q     <= row_i[8:0];
      s1_tidx_q   <= texel_index_i;
      s1_tval_q   <= texel_value_i;
      s1_sdepth_q <= sprite_depth_i;
      s1_dx_q     <= dx_d;
      s1_dy_q     <= dy_d;
      s1_sw_q     <= sw1;
      s1_sh_q     <= sh1;
      s2_negx_q   <= s1_dx_q[17];
      s2_bigx_q   <= !s1_dx_q[17] && (s1_dx_q[16:0] >= 17'(s1_sw_q));
      s2_negy_q   <= s1_dy_q[17];
      s2_bigy_q   <= !s1_dy_q[17] && (s1_dy_q[16:0] >= 17'(s1_sh_q));
      s2_nx_q     <= NW'(s1_dx_q[15:0]) * NW'(tex_w_i);
      s2_ny_q     <= NW'(s1_dy_q[15:0]) * NW'(tex_h_i);
      s2_sw_q     <= s1_sw_q;
      s2_sh_q     <= s1_sh_q;
    end
  end

  assign side_o  = s2_side_q;
  assign num_x_o = s2_nx_q;
  assign den_x_o = s2_sw_q;
  assign neg_x_o = s2_negx_q;
  assign big_x_o = s2_bigx_q;
  assign num_y_o = s2_ny_q;
  assign den_y_o = s2_sh_q;
  assign neg_y_o = s2_negy_q;
  assign big_y_o = s2_bigy_q;

endmodule
`default_nettype wire

@@ design/sptex_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sprite texture sampler coordinate divider
// Restoring division, one quotient bit per register stage, with clamping of
// the result to the texture side.
// ----------------------------------------------------------------------------
module sptex_div #(
  parameter int unsigned TEXTURE_SIDE_MAX = sptex_pkg::TEXTURE_SIDE_MAX_DEF
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   en_i,
  input  wire logic [15+$clog2(TEXTURE_SIDE_MAX+1):0] num_i,
  input  wire logic [15:0]                            den_i,
  input  wire logic                                   neg_i,
  input  wire logic                                   big_i,
  input  wire logic [$clog2(TEXTURE_SIDE_MAX)-1:0]    side_m1_i,
  output logic [$clog2(TEXTURE_SIDE_MAX)-1:0]         coord_o
);

  localparam int unsigned QW = $clog2(TEXTURE_SIDE_MAX);
  localparam int unsigned NW = 16 + $clog2(TEXTURE_SIDE_MAX + 1);

  logic [NW-1:0] rem_in [QW];
  logic [15:0]   den_in [QW];
  logic [QW-1:0] q_in   [QW];
  logic          neg_in [QW];
  logic          big_in [QW];

  logic [NW-1:0] rem_q [QW];
  logic [15:0]   den_q [QW];
  logic [QW-1:0] q_q   [QW];
  logic          neg_q [QW];
  logic          big_q [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int unsigned B = QW - 1 - j;
    logic [NW-1:0] dsh;
    logic          ge;

    if (j == 0) begin : g_first
      assign rem_in[j] = num_i;
      assign den_in[j] = den_i;
      assign q_in[j]   = '0;
      assign neg_in[j] = neg_i;
      assign big_in[j] = big_i;
    end else begin : g_next
      assign rem_in[j] = rem_q[j-1];
      assign den_in[j] = den_q[j-1];
      assign q_in[j]   = q_q[j-1];
      assign neg_in[j] = neg_q[j-1];
      assign big_in[j] = big_q[j-1];
    end

    assign dsh = NW'(den_in[j]) << B;
    assign ge  = rem_in[j] >= dsh;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= ge ? (rem_in[j] - dsh) : rem_in[j];
        q_q[j]   <= q_in[j] | (ge ? (QW'(1) << B) : '0);
        den_q[j] <= den_in[j];
        neg_q[j] <= neg_in[j];
        big_q[j] <= big_in[j];
      end
    end
  end

  assign coord_o = neg_q[QW-1] ? '0 : (big_q[QW-1] ? side_m1_i : q_q[QW-1]);

endmodule
`default_nettype wire

@@ design/sptex_texel.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sprite texture sampler texel stage
// Forms the texel address, keeps the texel store and registers the result
// beat after the transparency test.
// ----------------------------------------------------------------------------
module sptex_texel #(
  parameter int unsigned TEXTURE_SIDE_MAX = sptex_pkg::TEXTURE_SIDE_MAX_DEF,
  parameter int unsigned FRAMES_MAX       = sptex_pkg::FRAMES_MAX_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                en_i,
  input  wire sptex_pkg::side_t                    side_i,
  input  wire logic [$clog2(TEXTURE_SIDE_MAX)-1:0] tx_i,
  input  wire logic [$clog2(TEXTURE_SIDE_MAX)-1:0] ty_i,
  input  wire logic [3:0]                          frame_i,
  output logic                                     out_valid_o,
  output logic [9:0]                               pixel_x_o,
  output logic [8:0]                               pixel_y_o,
  output logic [31:0]                              pixel_color_o
);

  localparam int unsigned TEXELS = FRAMES_MAX * TEXTURE_SIDE_MAX * TEXTURE_SIDE_MAX;
  localparam int unsigned AW     = $clog2(TEXELS);

  logic [31:0]      tmem [TEXELS];
  logic [AW-1:0]    addr_d;
  logic [AW-1:0]    addr_q;
  sptex_pkg::side_t a_side_q;
  sptex_pkg::side_t m_side_q;
  logic [31:0]      rd_q;
  logic             out_valid_q;
  logic [9:0]       px_q;
  logic [8:0]       py_q;
  logic [31:0]      color_q;

  assign addr_d = side_i.twr ? AW'(side_i.tidx) :
                  (AW'(frame_i) * AW'(TEXTURE_SIDE_MAX * TEXTURE_SIDE_MAX) +
                   AW'(ty_i) * AW'(TEXTURE_SIDE_MAX) + AW'(tx_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_side_q    <= '0;
      m_side_q    <= '0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      a_side_q    <= side_i;
      m_side_q    <= a_side_q;
      out_valid_q <= m_side_q.shade && ((rd_q & sptex_pkg::OPAQUE_MASK) != 32'd0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      addr_q <= addr_d;
      if (a_side_q.twr) begin
        tmem[addr_q] <= a_side_q.tval;
      end
      rd_q    <= tmem[addr_q];
      px_q    <= m_side_q.px;
      py_q    <= m_side_q.py;
      color_q <= rd_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = px_q;
  assign pixel_y_o     = py_q;
  assign pixel_color_o = color_q;

endmodule
`default_nettype wire

@@ design/sprite_pixel_texture_sampler.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sprite pixel texture sampler
// Per-pixel stage of a billboard sprite renderer with a column depth test.
// ----------------------------------------------------------------------------
// The block takes one beat per clock while it is not stalled and returns at
// most one pixel beat for each shade beat, in order, through the front end,
// the coordinate dividers (one quotient bit per stage) and the texel stage.
// The whole pipeline advances together and freezes only while a finished
// pixel is held by a stall on the output; load beats and rejected pixels
// leave bubbles that never hold it back.
module sprite_pixel_texture_sampler #(
  parameter int unsigned SCREEN_WIDTH     = sptex_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT    = sptex_pkg::SCREEN_HEIGHT_DEF,
  parameter int unsigned TEXTURE_SIDE_MAX = sptex_pkg::TEXTURE_SIDE_MAX_DEF,
  parameter int unsigned FRAMES_MAX       = sptex_pkg::FRAMES_MAX_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [6:0]         cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         operation_i,
  input  wire logic signed [15:0] column_i,
  input  wire logic signed [15:0] row_i,
  input  wire logic signed [15:0] sprite_center_x_i,
  input  wire logic [15:0]        sprite_width_i,
  input  wire logic [15:0]        sprite_height_i,
  input  wire logic [31:0]        sprite_depth_i,
  input  wire logic [31:0]        depth_value_i,
  input  wire logic [14:0]        texel_index_i,
  input  wire logic [31:0]        texel_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [9:0]              pixel_x_o,
  output logic [8:0]              pixel_y_o,
  output logic [31:0]             pixel_color_o
);

  localparam int unsigned QW   = $clog2(TEXTURE_SIDE_MAX);
  localparam int unsigned SW_W = $clog2(TEXTURE_SIDE_MAX + 1);
  localparam int unsigned NW   = 16 + SW_W;
  localparam int unsigned TEXTURE_SIDE_MAX_RESET = 64;

  logic [6:0] tex_w_q;
  logic [6:0] tex_h_q;
  logic [3:0] frame_count_q;
  logic [2:0] anim_frame_q;

  logic            en;
  logic [SW_W-1:0] tw_lim;
  logic [SW_W-1:0] th_lim;
  logic [QW-1:0]   tw_m1;
  logic [QW-1:0]   th_m1;
  logic [3:0]      frame;

  sptex_pkg::side_t front_side;
  logic [NW-1:0]    num_x;
  logic [NW-1:0]    num_y;
  logic [15:0]      den_x;
  logic [15:0]      den_y;
  logic             neg_x;
  logic             neg_y;
  logic             big_x;
  logic             big_y;
  logic [QW-1:0]    tx;
  logic [QW-1:0]    ty;
  sptex_pkg::side_t side_dly_q [QW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tex_w_q       <= 7'(TEXTURE_SIDE_MAX_RESET);
      tex_h_q       <= 7'(TEXTURE_SIDE_MAX_RESET);
      frame_count_q <= 4'd0;
      anim_frame_q  <= 3'd0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        sptex_pkg::CFG_TEXTURE_WIDTH:   tex_w_q       <= cfg_data_i;
        sptex_pkg::CFG_TEXTURE_HEIGHT:  tex_h_q       <= cfg_data_i;
        sptex_pkg::CFG_FRAME_COUNT:     frame_count_q <= cfg_data_i[3:0];
        sptex_pkg::CFG_ANIMATION_FRAME: anim_frame_q  <= cfg_data_i[2:0];
        default: begin
        end
      endcase
    end
  end

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  assign tw_lim = (tex_w_q == 7'd0) ? SW_W'(1) :
                  ((32'(tex_w_q) > TEXTURE_SIDE_MAX) ? SW_W'(TEXTURE_SIDE_MAX) : SW_W'(tex_w_q));
  assign th_lim = (tex_h_q == 7'd0) ? SW_W'(1) :
                  ((32'(tex_h_q) > TEXTURE_SIDE_MAX) ? SW_W'(TEXTURE_SIDE_MAX) : SW_W'(tex_h_q));
  assign tw_m1  = QW'(tw_lim - SW_W'(1));
  assign th_m1  = QW'(th_lim - SW_W'(1));
  assign frame  = (frame_count_q != 4'd0) ?
                  sptex_pkg::frame_wrap(anim_frame_q, FRAMES_MAX) : 4'd0;

  sptex_front #(
    .SCREEN_WIDTH     (SCREEN_WIDTH),
    .SCREEN_HEIGHT    (SCREEN_HEIGHT),
    .TEXTURE_SIDE_MAX (TEXTURE_SIDE_MAX),
    .FRAMES_MAX       (FRAMES_MAX)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .en_i              (en),
    .in_valid_i        (in_valid_i),
    .operation_i       (operation_i),
    .column_i          (column_i),
    .row_i             (row_i),
    .sprite_center_x_i (sprite_center_x_i),
    .sprite_width_i    (sprite_width_i),
    .sprite_height_i   (sprite_height_i),
    .sprite_depth_i    (sprite_depth_i),
    .depth_value_i     (depth_value_i),
    .texel_index_i     (texel_index_i),
    .texel_value_i     (texel_value_i),
    .tex_w_i           (tw_lim),
    .tex_h_i           (th_lim),
    .side_o            (front_side),
    .num_x_o           (num_x),
    .den_x_o           (den_x),
    .neg_x_o           (neg_x),
    .big_x_o           (big_x),
    .num_y_o           (num_y),
    .den_y_o           (den_y),
    .neg_y_o           (neg_y),
    .big_y_o           (big_y)
  );

  sptex_div #(
    .TEXTURE_SIDE_MAX (TEXTURE_SIDE_MAX)
  ) u_div_x (
    .clk_i     (clk_i),
    .en_i      (en),
    .num_i     (num_x),
    .den_i     (den_x),
    .neg_i     (neg_x),
    .big_i     (big_x),
    .side_m1_i (tw_m1),
    .coord_o   (tx)
  );

  sptex_div #(
    .TEXTURE_SIDE_MAX (TEXTURE_SIDE_MAX)
  ) u_div_y (
    .clk_i     (clk_i),
    .en_i      (en),
    .num_i     (num_y),
    .den_i     (den_y),
    .neg_i     (neg_y),
    .big_i     (big_y),
    .side_m1_i (th_m1),
    .coord_o   (ty)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QW; i++) begin
        side_dly_q[i] <= '0;
      end
    end else if (en) begin
      side_dly_q[0] <= front_side;
      for (int i = 1; i < QW; i++) begin
        side_dly_q[i] <= side_dly_q[i-1];
      end
    end
  end

  sptex_texel #(
    .TEXTURE_SIDE_MAX (TEXTURE_SIDE_MAX),
    .FRAMES_MAX       (FRAMES_MAX)
  ) u_texel (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .side_i        (side_dly_q[QW-1]),
    .tx_i          (tx),
    .ty_i          (ty),
    .frame_i       (frame),
    .out_valid_o   (out_valid_o),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_color_o (pixel_color_o)
  );

endmodule
`default_nettype wire

@@ tb/sv/tb_sprite_pixel_texture_sampler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite pixel texture sampler testbench
// Drives load and shade beats through the sampler with random bursts, gaps
// and output stalls, predicts every drawn pixel from a local copy of the
// depth and texel stores, and checks each output beat field by field.
// ----------------------------------------------------------------------------
module tb_sprite_pixel_texture_sampler;

  localparam int          SCR_W       = 640;
  localparam int          SCR_H       = 480;
  localparam int          SIDE        = 64;
  localparam int          FRAMES      = 8;
  localparam int          STORE_SIZE  = FRAMES * SIDE * SIDE;
  localparam logic [1:0]  OP_RESERVED = 2'd3;
  localparam int          IDLE_LIMIT  = 4000;
  localparam int          DRAIN_WAIT  = 30;

  typedef struct {
    logic [1:0]         op;
    logic signed [15:0] col;
    logic signed [15:0] row;
    logic signed [15:0] cx;
    logic [15:0]        sw;
    logic [15:0]        sh;
    logic [31:0]        sdepth;
    logic [31:0]        dval;
    logic [14:0]        tidx;
    logic [31:0]        tval;
  } beat_t;

  typedef struct {
    logic [9:0]  x;
    logic [8:0]  y;
    logic [31:0] color;
  } pixel_t;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_NO_PIXEL, ROW_PIXEL} row_kind_e;

  typedef struct {
    beat_t     b;
    row_kind_e kind;
    pixel_t    px;
  } dir_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [1:0]        cfg_index_i;
  logic [6:0]        cfg_data_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [1:0]        operation_i;
  logic signed [15:0] column_i;
  logic signed [15:0] row_i;
  logic signed [15:0] sprite_center_x_i;
  logic [15:0]       sprite_width_i;
  logic [15:0]       sprite_height_i;
  logic [31:0]       sprite_depth_i;
  logic [31:0]       depth_value_i;
  logic [14:0]       texel_index_i;
  logic [31:0]       texel_value_i;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [9:0]        pixel_x_o;
  logic [8:0]        pixel_y_o;
  logic [31:0]       pixel_color_o;

  sprite_pixel_texture_sampler i_dut (.*);

  logic [31:0] depth_mem [SCR_W];
  logic [31:0] texel_mem [STORE_SIZE];
  bit          depth_set [SCR_W];
  bit          texel_set [STORE_SIZE];
  logic [6:0]  tex_w_reg, tex_h_reg;
  logic [3:0]  frame_cnt_reg;
  logic [2:0]  anim_frame_reg;

  pixel_t pending_pixels[$];
  int     errors = 0;
  int     beats_sent = 0;
  int     pixels_seen = 0;
  int     idle_cycles = 0;
  int     burst_left;
  int     stall_mode = 0;
  int     stall_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic longint side_eff(input logic [6:0] s);
    if (s == 0) return 1;
    if (s > SIDE) return SIDE;
    return longint'(s);
  endfunction

  function automatic longint coord(input longint d, input longint side, input longint size);
    longint t;
    if (d < 0) return 0;
    t = (d * side) / size;
    return (t >= side) ? side - 1 : t;
  endfunction

  function automatic int active_frame();
    return (frame_cnt_reg != 0) ? int'(anim_frame_reg) % FRAMES : 0;
  endfunction

  // Returns 1 when the shade beat passes the column and depth tests and its
  // texel address lies in the store; addr is the texel it then reads.
  function automatic bit shade_addr(input beat_t b, output longint addr);
    longint sw, sh, tx, ty;
    addr = 0;
    if (b.col < 0 || b.col >= SCR_W) return 0;
    if (!depth_set[b.col] || !(b.sdepth < depth_mem[b.col])) return 0;
    sw = (b.sw == 0) ? 1 : longint'(b.sw);
    sh = (b.sh == 0) ? 1 : longint'(b.sh);
    tx = coord(longint'(b.col) - longint'(b.cx) + sw / 2, side_eff(tex_w_reg), sw);
    ty = coord(longint'(b.row) - SCR_H / 2 + sh / 2, side_eff(tex_h_reg), sh);
    addr = longint'(active_frame()) * SIDE * SIDE + ty * SIDE + tx;
    return (addr >= 0 && addr < STORE_SIZE);
  endfunction

  function automatic bit sample_pixel(input beat_t b, output pixel_t px);
    longint addr;
    logic [31:0] c;
    px = '{default: '0};
    if (b.op == sptex_pkg::OP_LOAD_DEPTH) begin
      if (b.col >= 0 && b.col < SCR_W) begin
        depth_mem[b.col] = b.dval;
        depth_set[b.col] = 1;
      end
      return 0;
    end
    if (b.op == sptex_pkg::OP_LOAD_TEXEL) begin
      texel_mem[b.tidx] = b.tval;
      texel_set[b.tidx] = 1;
      return 0;
    end
    if (b.op != sptex_pkg::OP_SHADE || !shade_addr(b, addr)) return 0;
    c = texel_mem[addr];
    if ((c & sptex_pkg::OPAQUE_MASK) == 0 || b.row < 0 || b.row >= SCR_H) return 0;
    px.x = b.col[9:0];
    px.y = b.row[8:0];
    px.color = c;
    return 1;
  endfunction

  function automatic beat_t blank_beat(input logic [1:0] op);
    beat_t b;
    b = '{op: op, sw: 16'd1, sh: 16'd1, default: '0};
    return b;
  endfunction

  task automatic send_beat(input beat_t b, input row_kind_e kind, input pixel_t typed);
    pixel_t px;
    bit     hit;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk_i);
      burst_left = ($urandom_range(3, 0) == 0) ? 60 : int'($urandom_range(12, 1));
    end
    in_valid_i        <= 1'b1;
    operation_i       <= b.op;
    column_i          <= b.col;
    row_i             <= b.row;
    sprite_center_x_i <= b.cx;
    sprite_width_i    <= b.sw;
    sprite_height_i   <= b.sh;
    sprite_depth_i    <= b.sdepth;
    depth_value_i     <= b.dval;
    texel_index_i     <= b.tidx;
    texel_value_i     <= b.tval;
    do @(posedge clk_i); while (in_stall_o);
    burst_left--;
    beats_sent++;
    hit = sample_pixel(b, px);
    if (kind == ROW_PIXEL) pending_pixels.push_back(typed);
    else if (kind == ROW_PREDICT && hit) pending_pixels.push_back(px);
  endtask

  // Loads any store entry the shade beat would read before it is written.
  task automatic send_shade(input beat_t b);
    beat_t  pre;
    longint addr;
    pixel_t none;
    none = '{default: '0};
    if (b.col >= 0 && b.col < SCR_W && !depth_set[b.col]) begin
      pre = blank_beat(sptex_pkg::OP_LOAD_DEPTH);
      pre.col = b.col;
      pre.dval = $urandom();
      send_beat(pre, ROW_PREDICT, none);
    end
    if (shade_addr(b, addr) && !texel_set[addr]) begin
      pre = blank_beat(sptex_pkg::OP_LOAD_TEXEL);
      pre.tidx = addr[14:0];
      pre.tval = $urandom();
      send_beat(pre, ROW_PREDICT, none);
    end
    send_beat(b, ROW_PREDICT, none);
  endtask

  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [6:0] w, input logic [6:0] h,
                              input logic [3:0] fc, input logic [2:0] af);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= sptex_pkg::CFG_TEXTURE_WIDTH;
    cfg_data_i  <= w;
    @(posedge clk_i);
    cfg_index_i <= sptex_pkg::CFG_TEXTURE_HEIGHT;
    cfg_data_i  <= h;
    @(posedge clk_i);
    cfg_index_i <= sptex_pkg::CFG_FRAME_COUNT;
    cfg_data_i  <= {3'b000, fc};
    @(posedge clk_i);
    cfg_index_i <= sptex_pkg::CFG_ANIMATION_FRAME;
    cfg_data_i  <= {4'b0000, af};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tex_w_reg      = w;
    tex_h_reg      = h;
    frame_cnt_reg  = fc;
    anim_frame_reg = af;
  endtask

  function automatic beat_t random_beat();
    beat_t b;
    int    pick;
    b.op     = sptex_pkg::OP_SHADE;
    b.col    = 16'($urandom());
    b.row    = 16'($urandom());
    b.cx     = 16'($urandom());
    b.sw     = 16'($urandom());
    b.sh     = 16'($urandom());
    b.sdepth = $urandom();
    b.dval   = $urandom();
    b.tidx   = 15'($urandom());
    b.tval   = $urandom();
    pick = int'($urandom_range(99, 0));
    if (pick < 8) begin
      b.op = 2'($urandom_range(3, 0));
      return b;
    end
    if (pick < 22) begin
      b.op  = sptex_pkg::OP_LOAD_DEPTH;
      b.col = 16'($urandom_range(SCR_W - 1, 0));
    end else if (pick < 38) begin
      b.op   = sptex_pkg::OP_LOAD_TEXEL;
      b.tidx = 15'(active_frame() * SIDE * SIDE
                   + $urandom_range(side_eff(tex_h_reg) - 1, 0) * SIDE
                   + $urandom_range(side_eff(tex_w_reg) - 1, 0));
      if ($urandom_range(3, 0) == 0) b.tval[23:0] = '0;
    end else begin
      b.col = 16'($urandom_range(SCR_W - 1, 0));
      b.row = ($urandom_range(9, 0) == 0) ? 16'($urandom_range(520, 0) - 20)
                                          : 16'($urandom_range(SCR_H - 1, 0));
      b.cx  = 16'(b.col + $urandom_range(80, 0) - 40);
      if ($urandom_range(9, 0) != 0) begin
        b.sw = 16'($urandom_range(90, 0));
        b.sh = 16'($urandom_range(90, 0));
      end
      if ($urandom_range(2, 0) != 0) b.sdepth = b.sdepth >> $urandom_range(8, 1);
    end
    return b;
  endfunction

  function automatic beat_t mk(input logic [1:0] op, input int col, input int row,
                               input int cx, input int sw, input int sh,
                               input logic [31:0] sd, input logic [31:0] dv,
                               input int ti, input logic [31:0] tv);
    beat_t b;
    b = '{op, col[15:0], row[15:0], cx[15:0], sw[15:0], sh[15:0], sd, dv, ti[14:0], tv};
    return b;
  endfunction

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = int'($urandom_range(3, 0));
      stall_left = int'($urandom_range(200, 20));
    end
    stall_left--;
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(99, 0) < 30);
      2: out_stall_i <= (stall_left % 4 == 0);
      default: out_stall_i <= ($urandom_range(99, 0) < 75);
    endcase
  end

  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      pixels_seen++;
      if (pending_pixels.size() == 0) begin
        report("unexpected pixel_x", 32'(pixel_x_o), 32'd0);
      end else begin
        want = pending_pixels.pop_front();
        if (pixel_x_o != want.x) report("pixel_x", 32'(pixel_x_o), 32'(want.x));
        if (pixel_y_o != want.y) report("pixel_y", 32'(pixel_y_o), 32'(want.y));
        if (pixel_color_o != want.color) report("pixel_color", pixel_color_o, want.color);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout with %0d pixels outstanding", pending_pixels.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    dir_row_t rows[$];
    pixel_t   none;
    logic [6:0] w, h;
    none = '{default: '0};
    burst_left = 0;
    rst_ni = 1'b0; cfg_we_i = 1'b0; cfg_index_i = sptex_pkg::CFG_TEXTURE_WIDTH;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    operation_i = sptex_pkg::OP_LOAD_DEPTH; column_i = '0; row_i = '0;
    sprite_center_x_i = '0;
    sprite_width_i = '0; sprite_height_i = '0; sprite_depth_i = '0; depth_value_i = '0;
    texel_index_i = '0; texel_value_i = '0;
    tex_w_reg = 7'd64; tex_h_reg = 7'd64; frame_cnt_reg = '0; anim_frame_reg = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    rows.push_back('{mk(sptex_pkg::OP_LOAD_DEPTH, 0, 0, 0, 1, 1, 0, 32'h0001_0000, 0, 0),
                     ROW_NO_PIXEL, none});
    rows.push_back('{mk(sptex_pkg::OP_LOAD_DEPTH, 639, 0, 0, 1, 1, 0, 32'hFFFF_FFFF, 0, 0),
                     ROW_NO_PIXEL, none});
    rows.push_back('{mk(sptex_pkg::OP_LOAD_DEPTH, -1, 0, 0, 1, 1, 0, 0, 0, 0),
                     ROW_NO_PIXEL, none});
    rows.push_back('{mk(sptex_pkg::OP_LOAD_DEPTH, 640, 0, 0, 1, 1, 0, 0, 0, 0),
                     ROW_NO_PIXEL, none});
    rows.push_back('{mk(sptex_pkg::OP_LOAD_DEPTH, -32768, 0, 0, 1, 1, 0, 0, 0, 0),
                     ROW_NO_PIXEL, none});
    rows.push_back('{mk(sptex_pkg::OP_LOAD_TEXEL, 0, 0, 0, 1, 1, 0, 0, 0, 32'hFF00_0000),
                     ROW_NO_PIXEL, none});
    rows.push_back('{mk(sptex_pkg::OP_LOAD_TEXEL, 0, 0, 0, 1, 1, 0, 0, 4032, 32'h1234_5678),
                     ROW_NO_PIXEL, none});
    rows.push_back('{mk(sptex_pkg::OP_LOAD_TEXEL, 0, 0, 0, 1, 1, 0, 0, 32767, 32'hFFFF_FFFF),
                     ROW_NO_PIXEL, none});
    rows.push_back('{mk(sptex_pkg::OP_SHADE, 639, 479, 639, 1, 1, 0, 0, 0, 0), ROW_PIXEL,
                     '{10'd639, 9'd479, 32'h1234_5678}});
    rows.push_back('{mk(sptex_pkg::OP_SHADE, 639, 479, 639, 0, 0, 0, 0, 0, 0), ROW_PIXEL,
                     '{10'd639, 9'd479, 32'h1234_5678}});
    rows.push_back('{mk(sptex_pkg::OP_SHADE, 0, 10, 0, 1, 1, 32'h0001_0000, 0, 0, 0),
                     ROW_NO_PIXEL, none});
    rows.push_back('{mk(sptex_pkg::OP_SHADE, -1, 10, 0, 1, 1, 0, 0, 0, 0),
                     ROW_NO_PIXEL, none});
    rows.push_back('{mk(sptex_pkg::OP_SHADE, 640, 10, 0, 1, 1, 0, 0, 0, 0),
                     ROW_NO_PIXEL, none});
    rows.push_back('{mk(sptex_pkg::OP_SHADE, 639, 480, 639, 1, 1, 0, 0, 0, 0),
                     ROW_NO_PIXEL, none});
    rows.push_back('{mk(sptex_pkg::OP_SHADE, 639, -1, 639, 1, 1, 0, 0, 0, 0),
                     ROW_NO_PIXEL, none});
    rows.push_back('{mk(sptex_pkg::OP_SHADE, 639, 240, 639, 1, 1, 0, 0, 0, 0),
                     ROW_NO_PIXEL, none});
    rows.push_back('{mk(sptex_pkg::OP_SHADE, 0, 5, 0, 1, 1, 32'hFFFF, 0, 0, 0),
                     ROW_PREDICT, none});
    rows.push_back('{mk(sptex_pkg::OP_SHADE, 639, 100, -32768, 65535, 65535,
                        32'hFFFF_FFFE, 0, 0, 0),
                     ROW_PREDICT, none});
    rows.push_back('{mk(OP_RESERVED, 639, 479, 639, 1, 1, 0, 0, 0, 0), ROW_NO_PIXEL, none});
    foreach (rows[i]) begin
      if (rows[i].kind == ROW_PREDICT) send_shade(rows[i].b);
      else send_beat(rows[i].b, rows[i].kind, rows[i].px);
    end
    drain_and_settle();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_config(7'd64, 7'd64, 4'd0, 3'd0);
        1: write_config(7'd1, 7'd1, 4'd8, 3'd7);
        2: write_config(7'd0, 7'd127, 4'd3, 3'd5);
        3: write_config(7'd37, 7'd13, 4'd1, 3'd0);
        4: write_config(7'd64, 7'd1, 4'd15, 3'd2);
        default: begin
          w = 7'($urandom_range(70, 0));
          h = 7'($urandom_range(70, 0));
          write_config(w, h, 4'($urandom_range(8, 0)), 3'($urandom_range(7, 0)));
        end
      endcase
      for (int n = 0; n < 100; n++) begin
        beat_t b;
        b = random_beat();
        if (b.op == sptex_pkg::OP_SHADE) send_shade(b);
        else send_beat(b, ROW_PREDICT, none);
      end
      drain_and_settle();
    end

    $display("Sent %0d beats over six texture settings; checked %0d drawn pixels.",
             beats_sent, pixels_seen);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/sptex_pkg.sv
design/sptex_front.sv
design/sptex_div.sv
design/sptex_texel.sv
design/sprite_pixel_texture_sampler.sv
tb/sv/tb_sprite_pixel_texture_sampler.sv
